FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every clock while out of reset
`define TUN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tun assertion failed");
// expression must never be true while out of reset
`define TUN_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("tun forbidden condition");
`else
`define TUN_ASSERT(lbl, clk, rstn, prop)
`define TUN_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: rtl/tun_pkg.sv
// Shared types and constants of the triangle unit normal block.
// No dependencies.
package tun_pkg;
  // width of each output normal component
  localparam int OUT_W = 16;

  // per-stage control travelling with each triangle
  typedef struct packed {
    logic valid;
    logic degenerate;
  } tun_ctl_t;
endpackage

FILE: rtl/tun_front.sv
// Front end: edge vectors, cross product, magnitudes, sum of squares.
// Depends on tun_pkg.
module tun_front #(
  parameter int CB = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_v,
  input  logic signed [CB-1:0]  a_x, a_y, a_z,
  input  logic signed [CB-1:0]  b_x, b_y, b_z,
  input  logic signed [CB-1:0]  c_x, c_y, c_z,
  output tun_pkg::tun_ctl_t     ctl_o,
  output logic [2*(2*CB+2)+1:0] sum_o,
  output logic [2*CB+1:0]       mag_o [3],
  output logic [2:0]            sgn_o
);
  import tun_pkg::*;

  localparam int DW   = CB + 1;
  localparam int NW   = 2 * CB + 3;
  localparam int MAGW = 2 * CB + 2;
  localparam int H    = MAGW / 2;
  localparam int SW   = 2 * (MAGW + 1);

  logic [4:0] v_r;
  logic signed [DW-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic signed [NW-1:0] n_r [3];
  logic [MAGW-1:0] m3_r [3], m4_r [3], m5_r [3];
  logic [2:0] s3_r, s4_r, s5_r;
  logic d3_r, d4_r, d5_r, d6_r;
  logic [2*H-1:0] hh_r [3], hl_r [3], ll_r [3];
  logic [SW-1:0] sq_r [3];
  logic [SW-1:0] sum_r;
  logic [MAGW-1:0] m6_r [3];
  logic [2:0] s6_r;
  logic vo_r;

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[3:0], in_v};
      vo_r <= v_r[4];
    end
  end

  // edges, cross product, magnitudes, partial products, squares, sum
  always_ff @(posedge clk) begin
    x1_r <= DW'(a_x) - DW'(b_x);
    y1_r <= DW'(a_y) - DW'(b_y);
    z1_r <= DW'(a_z) - DW'(b_z);
    x2_r <= DW'(b_x) - DW'(c_x);
    y2_r <= DW'(b_y) - DW'(c_y);
    z2_r <= DW'(b_z) - DW'(c_z);

    n_r[0] <= NW'(y1_r) * NW'(z2_r) - NW'(z1_r) * NW'(y2_r);
    n_r[1] <= NW'(z1_r) * NW'(x2_r) - NW'(x1_r) * NW'(z2_r);
    n_r[2] <= NW'(x1_r) * NW'(y2_r) - NW'(y1_r) * NW'(x2_r);

    for (int i = 0; i < 3; i++) begin
      s3_r[i] <= n_r[i][NW-1];
      m3_r[i] <= n_r[i][NW-1] ? MAGW'(-n_r[i]) : MAGW'(n_r[i]);
    end
    d3_r <= (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);

    for (int i = 0; i < 3; i++) begin
      hh_r[i] <= m3_r[i][MAGW-1:H] * m3_r[i][MAGW-1:H];
      hl_r[i] <= m3_r[i][MAGW-1:H] * m3_r[i][H-1:0];
      ll_r[i] <= m3_r[i][H-1:0] * m3_r[i][H-1:0];
      m4_r[i] <= m3_r[i];
      sq_r[i] <= (SW'(hh_r[i]) << (2 * H)) + (SW'(hl_r[i]) << (H + 1)) + SW'(ll_r[i]);
      m5_r[i] <= m4_r[i];
      m6_r[i] <= m5_r[i];
    end
    s4_r <= s3_r;
    s5_r <= s4_r;
    s6_r <= s5_r;
    d4_r <= d3_r;
    d5_r <= d4_r;
    d6_r <= d5_r;
    sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  assign ctl_o.valid      = vo_r;
  assign ctl_o.degenerate = d6_r;
  assign sum_o            = sum_r;
  assign mag_o            = m6_r;
  assign sgn_o            = s6_r;
endmodule

FILE: rtl/tun_sqrt_cell.sv
// One cell of the digit-by-digit square root chain: one root bit per cell.
// Depends on tun_pkg.
module tun_sqrt_cell #(
  parameter int RW   = 35,
  parameter int SIDE = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              v_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [2*RW-1:0]   sum_i,
  input  logic [SIDE-1:0]   side_i,
  output logic              v_o,
  output logic [RW+1:0]     rem_o,
  output logic [RW-1:0]     root_o,
  output logic [2*RW-1:0]   sum_o,
  output logic [SIDE-1:0]   side_o
);
  import tun_pkg::*;

  logic [RW+1:0] t, tr;
  logic ge;

  // bring down two bits, try root*4+1
  always_comb begin
    t  = {rem_i[RW-1:0], sum_i[2*RW-1 -: 2]};
    tr = {root_i, 2'b01};
    ge = (t >= tr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_o  <= ge ? (t - tr) : t;
    root_o <= {root_i[RW-2:0], ge};
    sum_o  <= {sum_i[2*RW-3:0], 2'b00};
    side_o <= side_i;
  end
endmodule

FILE: rtl/tun_div_cell.sv
// One cell of the restoring divider chain: one quotient bit per cell.
// Depends on tun_pkg.
module tun_div_cell #(
  parameter int RW   = 35,
  parameter int QW   = 15,
  parameter int SIDE = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            v_i,
  input  logic [RW:0]     rem_i,
  input  logic [RW-1:0]   len_i,
  input  logic [QW-1:0]   q_i,
  input  logic [SIDE-1:0] side_i,
  output logic            v_o,
  output logic [RW:0]     rem_o,
  output logic [RW-1:0]   len_o,
  output logic [QW-1:0]   q_o,
  output logic [SIDE-1:0] side_o
);
  import tun_pkg::*;

  logic ge;
  logic [RW:0] d;

  // subtract divisor if it fits, then shift remainder up
  always_comb begin
    ge = (rem_i >= {1'b0, len_i});
    d  = ge ? (rem_i - {1'b0, len_i}) : rem_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_o  <= {d[RW-1:0], 1'b0};
    len_o  <= len_i;
    q_o    <= {q_i[QW-2:0], ge};
    side_o <= side_i;
  end
endmodule

FILE: rtl/triangle_unit_normal_top.sv
// Top level: triangle unit normal, front end plus square root and divider chains.
// Depends on tun_pkg, tun_front, tun_sqrt_cell, tun_div_cell, assert_macros.svh.
//
//  channel | ports                     | handshake
//  input   | in_a_* in_b_* in_c_*      | transfer when start && !busy
//  result  | out_unit_* out_degenerate | out_valid strobe, one cycle
//
// One triangle per cycle; busy is always low.
// Each result passes through the front end, the root cell chain (one root bit
// per cell), the divider chain and a final output register.
// Reset (rst_n low, synchronous) clears all valid bits; no results in flight.
// The receiver cannot stall; each result shows for exactly one cycle.
`include "assert_macros.svh"
module triangle_unit_normal_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_a_x, in_a_y, in_a_z,
  input  logic signed [COORD_BITS-1:0]  in_b_x, in_b_y, in_b_z,
  input  logic signed [COORD_BITS-1:0]  in_c_x, in_c_y, in_c_z,
  output logic                          out_valid,
  output logic signed [tun_pkg::OUT_W-1:0] out_unit_x,
  output logic signed [tun_pkg::OUT_W-1:0] out_unit_y,
  output logic signed [tun_pkg::OUT_W-1:0] out_unit_z,
  output logic                          out_degenerate
);
  import tun_pkg::*;

  localparam int MAGW = 2 * COORD_BITS + 2;
  localparam int RW   = MAGW + 1;
  localparam int SW   = 2 * RW;
  localparam int QW   = FRAC_BITS + 1;
  localparam int QWX  = (QW > OUT_W) ? QW : OUT_W;
  localparam int SIDE = 3 * MAGW + 4;
  localparam int LAT  = 6 + RW + QW + 1;

  tun_ctl_t        f_ctl;
  logic [SW-1:0]   f_sum;
  logic [MAGW-1:0] f_mag [3];
  logic [2:0]      f_sgn;

  assign busy = 1'b0;

  tun_front #(.CB(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_v(start && !busy),
    .a_x(in_a_x), .a_y(in_a_y), .a_z(in_a_z),
    .b_x(in_b_x), .b_y(in_b_y), .b_z(in_b_z),
    .c_x(in_c_x), .c_y(in_c_y), .c_z(in_c_z),
    .ctl_o(f_ctl), .sum_o(f_sum), .mag_o(f_mag), .sgn_o(f_sgn)
  );

  // square root chain; side carries magnitudes, signs and degenerate flag
  logic            sv   [RW+1];
  logic [RW+1:0]   srem [RW+1];
  logic [RW-1:0]   sroot[RW+1];
  logic [SW-1:0]   ssum [RW+1];
  logic [SIDE-1:0] sside[RW+1];

  assign sv[0]    = f_ctl.valid;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign ssum[0]  = f_sum;
  assign sside[0] = {f_ctl.degenerate, f_sgn, f_mag[2], f_mag[1], f_mag[0]};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    tun_sqrt_cell #(.RW(RW), .SIDE(SIDE)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .v_i(sv[i]), .rem_i(srem[i]), .root_i(sroot[i]), .sum_i(ssum[i]),
      .side_i(sside[i]),
      .v_o(sv[i+1]), .rem_o(srem[i+1]), .root_o(sroot[i+1]), .sum_o(ssum[i+1]),
      .side_o(sside[i+1])
    );
  end

  // three divider lanes, one per component; side is {degenerate, sign}
  logic          dv   [3][QW+1];
  logic [RW:0]   drem [3][QW+1];
  logic [RW-1:0] dlen [3][QW+1];
  logic [QW-1:0] dq   [3][QW+1];
  logic [1:0]    dside[3][QW+1];

  for (genvar j = 0; j < 3; j++) begin : g_lane
    assign dv[j][0]    = sv[RW];
    assign drem[j][0]  = (RW + 1)'(sside[RW][j*MAGW +: MAGW]);
    assign dlen[j][0]  = sroot[RW];
    assign dq[j][0]    = '0;
    assign dside[j][0] = {sside[RW][SIDE-1], sside[RW][3*MAGW+j]};
    for (genvar k = 0; k < QW; k++) begin : g_div
      tun_div_cell #(.RW(RW), .QW(QW), .SIDE(2)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .v_i(dv[j][k]), .rem_i(drem[j][k]), .len_i(dlen[j][k]), .q_i(dq[j][k]),
        .side_i(dside[j][k]),
        .v_o(dv[j][k+1]), .rem_o(drem[j][k+1]), .len_o(dlen[j][k+1]),
        .q_o(dq[j][k+1]), .side_o(dside[j][k+1])
      );
    end
  end

  // apply sign, force zero on a degenerate triangle
  logic [QWX-1:0]   qe [3];
  logic [QWX-1:0]   qs [3];
  logic [OUT_W-1:0] u_nxt [3];
  logic [OUT_W-1:0] u_r [3];
  logic             v_r, d_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qe[j]    = QWX'(dq[j][QW]);
      qs[j]    = dside[j][QW][0] ? (~qe[j] + 1'b1) : qe[j];
      u_nxt[j] = dside[0][QW][1] ? '0 : qs[j][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= dv[0][QW];
    end
  end

  always_ff @(posedge clk) begin
    d_r <= dside[0][QW][1];
    u_r <= u_nxt;
  end

  assign out_valid      = v_r;
  assign out_unit_x     = u_r[0];
  assign out_unit_y     = u_r[1];
  assign out_unit_z     = u_r[2];
  assign out_degenerate = d_r;

  // checks
  `TUN_NEVER(a_never_busy, clk, rst_n, busy)
  `TUN_ASSERT(a_latency, clk, rst_n, start |-> ##LAT out_valid)
  `TUN_NEVER(a_deg_zero, clk, rst_n,
    out_valid && out_degenerate && (out_unit_x != '0 || out_unit_y != '0 || out_unit_z != '0))
  `TUN_NEVER(a_lanes_aligned, clk, rst_n, dv[0][QW] != dv[2][QW])
endmodule

FILE: sim/tb.sv
// Testbench for triangle_unit_normal_top: drives triangles and checks unit normals.
// Depends on tun_pkg and the triangle_unit_normal_top RTL.
`timescale 1ns / 1ps
module tb;
  import tun_pkg::*;

  localparam int CB = 16;
  localparam int FB = 14;
  localparam int LATENCY = 6 + (2 * CB + 3) + (FB + 1) + 1;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [OUT_W-1:0] ux;
    logic signed [OUT_W-1:0] uy;
    logic signed [OUT_W-1:0] uz;
    logic                    degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [CB-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic signed [CB-1:0] in_c_x = '0, in_c_y = '0, in_c_z = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_unit_x, out_unit_y, out_unit_z;
  logic out_degenerate;

  normal_t expected_normals[$];
  int  n_errors = 0;
  int  n_checked = 0;
  int  n_degen = 0;
  int  n_sent = 0;
  longint cycles = 0;

  triangle_unit_normal_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_c_x(in_c_x), .in_c_y(in_c_y), .in_c_z(in_c_z),
    .out_valid(out_valid), .out_unit_x(out_unit_x), .out_unit_y(out_unit_y),
    .out_unit_z(out_unit_z), .out_degenerate(out_degenerate)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** triangle_unit_normal_top: FAILED **");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
  endtask

  // integer square root, floor
  function automatic logic [63:0] floor_root(input logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 55; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= s) r = c;
    end
    return r;
  endfunction

  // trunc(comp * 2^FB / len), masked to the output width
  function automatic logic [OUT_W-1:0] scaled_comp(input longint comp, input logic [63:0] len);
    logic [127:0] num;
    logic [63:0]  q;
    num = 128'(comp < 0 ? -comp : comp) << FB;
    q = 64'(num / 128'(len));
    if (comp < 0) q = -q;
    return q[OUT_W-1:0];
  endfunction

  function automatic normal_t predict_normal(input logic signed [CB-1:0] v[9]);
    longint x1, y1, z1, x2, y2, z2, nx, ny, nz;
    logic [127:0] s;
    logic [63:0]  len;
    normal_t r;
    x1 = longint'(v[0]) - longint'(v[3]);
    y1 = longint'(v[1]) - longint'(v[4]);
    z1 = longint'(v[2]) - longint'(v[5]);
    x2 = longint'(v[3]) - longint'(v[6]);
    y2 = longint'(v[4]) - longint'(v[7]);
    z2 = longint'(v[5]) - longint'(v[8]);
    nx = y1 * z2 - z1 * y2;
    ny = z1 * x2 - x1 * z2;
    nz = x1 * y2 - y1 * x2;
    if (nx == 0 && ny == 0 && nz == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, degen: 1'b1};
      return r;
    end
    // squares need more than 64 bits
    s = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
    len = floor_root(s);
    r.ux = scaled_comp(nx, len);
    r.uy = scaled_comp(ny, len);
    r.uz = scaled_comp(nz, len);
    r.degen = 1'b0;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    normal_t w;
    if (rst_n && out_valid) begin
      if (expected_normals.size() == 0) begin
        report("unexpected result transfer", 1, 0);
      end else begin
        w = expected_normals.pop_front();
        if (out_unit_x !== w.ux) report("unit_x", out_unit_x, w.ux);
        if (out_unit_y !== w.uy) report("unit_y", out_unit_y, w.uy);
        if (out_unit_z !== w.uz) report("unit_z", out_unit_z, w.uz);
        if (out_degenerate !== w.degen) report("degenerate", out_degenerate, w.degen);
        if (w.degen) n_degen++;
        n_checked++;
      end
    end
  end

  // one triangle transfer, with a random gap first; start stays high afterwards
  task automatic send_triangle(input logic signed [CB-1:0] v[9], input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) start <= 1'b0;
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_a_x <= v[0]; in_a_y <= v[1]; in_a_z <= v[2];
    in_b_x <= v[3]; in_b_y <= v[4]; in_b_z <= v[5];
    in_c_x <= v[6]; in_c_y <= v[7]; in_c_z <= v[8];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_normals.push_back(predict_normal(v));
    n_sent++;
  endtask

  bit burst_mode = 0;

  // stop sending and wait for every expected result
  task automatic drain();
    start <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
  endtask

  // extremes, axes, degenerate cases
  task automatic test_directed();
    logic signed [CB-1:0] v[9];
    logic signed [CB-1:0] mx, mn;
    mx = 16'sh7fff; mn = 16'sh8000;
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_triangle(v);
    v = '{5, 5, 5, 5, 5, 5, 5, 5, 5}; send_triangle(v);
    v = '{0, 0, 0, 1, 1, 1, 2, 2, 2}; send_triangle(v);
    v = '{1, 0, 0, 0, 0, 0, 0, 1, 0}; send_triangle(v);
    v = '{0, 1, 0, 0, 0, 0, 0, 0, 1}; send_triangle(v);
    v = '{0, 0, 1, 0, 0, 0, 1, 0, 0}; send_triangle(v);
    v = '{mx, mx, mx, mn, mn, mn, mx, mx, mx}; send_triangle(v);
    v = '{mx, mn, mx, mn, mx, mn, mx, mx, mn}; send_triangle(v);
    v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn}; send_triangle(v);
    v = '{mx, mn, 0, mn, mx, 0, 0, 0, mx}; send_triangle(v);
    v = '{mx, 0, 0, 0, mx, 0, 0, 0, mx}; send_triangle(v);
    v = '{mn, 0, 0, 0, mn, 0, 0, 0, mn}; send_triangle(v);
    v = '{1, 2, 3, 4, 6, 8, 3, 1, -7}; send_triangle(v);
    v = '{-1, -1, -1, -1, -1, -1, mx, mn, 0}; send_triangle(v);
    v = '{3, 0, 0, 0, 4, 0, 0, 0, 0}; send_triangle(v);
    v = '{mx, mx, 0, mn, mn, 0, 0, 0, 0}; send_triangle(v);
    v = '{1, 1, 0, 2, 1, 0, 2, 2, 1}; send_triangle(v);
  endtask

  // random triangles: full range, small coordinates, collinear sets
  task automatic test_random(input int count);
    logic signed [CB-1:0] v[9];
    int kind;
    int k;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      burst_mode = (i % 200) < 30;
      for (int j = 0; j < 9; j++) begin
        if (kind < 5) v[j] = CB'($urandom);
        else if (kind < 8) v[j] = CB'($urandom_range(0, 16) - 8);
        else v[j] = CB'($urandom_range(0, 400) - 200);
      end
      if (kind == 9) begin
        // collinear: c = b + k*(b - a)
        k = $urandom_range(0, 4) - 2;
        for (int j = 0; j < 3; j++) v[6 + j] = v[3 + j] + CB'(k) * (v[3 + j] - v[j]);
      end
      send_triangle(v, burst_mode);
    end
    burst_mode = 0;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    // hold off until the pipeline has emptied
    drain();
    test_random(600);
    drain();
    test_random(600);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d triangles, checked %0d normals, %0d of them degenerate",
             n_sent, n_checked, n_degen);
    if (n_errors == 0 && expected_normals.size() == 0) begin
      $display("** triangle_unit_normal_top: PASSED **");
    end else begin
      $display("%0d errors, %0d results missing", n_errors, expected_normals.size());
      $display("** triangle_unit_normal_top: FAILED **");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/tun_pkg.sv
rtl/tun_front.sv
rtl/tun_sqrt_cell.sv
rtl/tun_div_cell.sv
rtl/triangle_unit_normal_top.sv
sim/tb.sv
